@@ rtl/npe_pkg.sv @@
// Package for the 3D nearest-point search block.
// Holds the controller state type, the command struct and the fixed field widths.
// No dependencies.
package npe_pkg;

    // Fixed widths of the transaction fields.
    localparam int PT_W       = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IDX_OUT_W  = 8;
    localparam int DIST_W     = 25;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_Z = 2'd2;

    // Square-and-accumulate step codes: three products, then the final add.
    localparam logic [1:0] SQ_FIRST = 2'd0;
    localparam logic [1:0] SQ_LAST  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_BEST,
        S_ROOT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       capture;    // latch coordinate differences and last flag
        logic       sq_step;    // one square-and-accumulate step
        logic [1:0] sel;        // axis of that step
        logic       best;       // update running best and item count, seed the root
        logic       root_step;  // one result bit of the square root
        logic       out_load;   // move the finished result into the output register
    } t_dp_cmd;

endpackage

@@ rtl/npe_ctrl.sv @@
// Controller of the 3D nearest-point search block.
// Sequences capture, squaring, best update and square root; owns the input ready and the output valid flag.
// Depends on npe_pkg.
module npe_ctrl #(
    parameter int COORD_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output npe_pkg::t_dp_cmd o_cmd
);

    localparam int ROOT_STEPS = COORD_BITS + 1;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    npe_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npe_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.sel    = r_cnt[1:0];
        case (r_state)
            npe_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = npe_pkg::S_SQR;
                end
            end
            npe_pkg::S_SQR: begin
                o_cmd.sq_step = 1'b1;
                if (r_cnt[1:0] == npe_pkg::SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = npe_pkg::S_BEST;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            npe_pkg::S_BEST: begin
                o_cmd.best = 1'b1;
                n_cnt      = '0;
                n_state    = npe_pkg::S_ROOT;
            end
            npe_pkg::S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = npe_pkg::S_OUT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            npe_pkg::S_OUT: begin
                // hold until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = npe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = npe_pkg::S_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/npe_dpath.sv @@
// Datapath of the 3D nearest-point search block.
// Reference registers, shared squarer, running best, bit-serial square root, output register.
// Depends on npe_pkg.
module npe_dpath #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [npe_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [npe_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic signed [npe_pkg::PT_W-1:0]  i_pt_x,
    input  logic signed [npe_pkg::PT_W-1:0]  i_pt_y,
    input  logic signed [npe_pkg::PT_W-1:0]  i_pt_z,
    input  logic                             i_last_point,
    input  npe_pkg::t_dp_cmd                 i_cmd,
    output logic [npe_pkg::IDX_OUT_W-1:0]    o_point_index,
    output logic [npe_pkg::DIST_W-1:0]       o_distance,
    output logic                             o_set_done,
    output logic [npe_pkg::IDX_OUT_W-1:0]    o_closest_index
);

    localparam int CW     = COORD_BITS;
    localparam int DW     = CW + 1;        // signed difference
    localparam int SW     = 2 * CW + 2;    // sum of three squares
    localparam int PW     = 2 * CW;        // one square
    localparam int ROOT_W = CW + 1;
    localparam int REM_W  = CW + 4;
    localparam int IDX_W  = $clog2(MAX_POINTS);

    // Coordinate as the block sees it: low COORD_BITS of the zero-extended field.
    function automatic logic [CW-1:0] to_coord(input logic [npe_pkg::PT_W-1:0] v);
        logic [npe_pkg::PT_W+CW-1:0] z;
        z = (npe_pkg::PT_W + CW)'(v);
        return z[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [DW-1:0] d;
        logic [DW-1:0] n;
        d = {a[CW-1], a} - {b[CW-1], b};
        n = ~d + DW'(1);
        return d[DW-1] ? n[CW-1:0] : d[CW-1:0];
    endfunction

    logic [npe_pkg::PT_W-1:0] r_ref_x, r_ref_y, r_ref_z;

    logic [CW-1:0]     r_abs [3];
    logic              r_last;
    logic [PW-1:0]     r_prod;
    logic [SW-1:0]     r_acc;

    logic [IDX_W-1:0]  r_count;
    logic [SW-1:0]     r_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic [IDX_W-1:0]  r_res_idx;
    logic [IDX_W-1:0]  r_res_closest;

    logic [SW-1:0]     r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [npe_pkg::IDX_OUT_W-1:0] r_o_idx, r_o_closest;
    logic [npe_pkg::DIST_W-1:0]    r_o_dist;
    logic                          r_o_done;

    logic              take_best;
    logic [REM_W-1:0]  shift_rem;
    logic [REM_W-1:0]  trial;
    logic              root_ge;

    assign take_best = (r_count == '0) || (r_acc <= r_best);
    assign shift_rem = {r_rem[REM_W-3:0], r_rad[SW-1:SW-2]};
    assign trial     = REM_W'({r_root, 2'b01});
    assign root_ge   = (shift_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_ref_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                npe_pkg::CFG_REF_X: r_ref_x <= i_cfg_wdata;
                npe_pkg::CFG_REF_Y: r_ref_y <= i_cfg_wdata;
                npe_pkg::CFG_REF_Z: r_ref_z <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_best     <= '0;
            r_best_idx <= '0;
        end else if (i_cmd.best) begin
            if (r_last) begin
                // end of set: clear the running state
                r_count    <= '0;
                r_best     <= '0;
                r_best_idx <= '0;
            end else begin
                if (take_best) begin
                    r_best     <= r_acc;
                    r_best_idx <= r_count;
                end
                if (r_count != IDX_W'(MAX_POINTS - 1)) begin
                    r_count <= r_count + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_abs[0] <= abs_diff(to_coord(i_pt_x), to_coord(r_ref_x));
            r_abs[1] <= abs_diff(to_coord(i_pt_y), to_coord(r_ref_y));
            r_abs[2] <= abs_diff(to_coord(i_pt_z), to_coord(r_ref_z));
            r_last   <= i_last_point;
        end
        if (i_cmd.sq_step) begin
            if (i_cmd.sel != npe_pkg::SQ_LAST) begin
                r_prod <= PW'(r_abs[i_cmd.sel]) * PW'(r_abs[i_cmd.sel]);
            end
            r_acc <= (i_cmd.sel == npe_pkg::SQ_FIRST) ? '0 : r_acc + SW'(r_prod);
        end
        if (i_cmd.best) begin
            r_res_idx     <= r_count;
            r_res_closest <= take_best ? r_count : r_best_idx;
            r_rad         <= r_acc;
            r_rem         <= '0;
            r_root        <= '0;
        end
        if (i_cmd.root_step) begin
            // one result bit: bring in two radicand bits, try to subtract 4*root+1
            r_rem  <= root_ge ? shift_rem - trial : shift_rem;
            r_root <= {r_root[ROOT_W-2:0], root_ge};
            r_rad  <= {r_rad[SW-3:0], 2'b00};
        end
        if (i_cmd.out_load) begin
            r_o_idx     <= npe_pkg::IDX_OUT_W'(r_res_idx);
            r_o_closest <= npe_pkg::IDX_OUT_W'(r_res_closest);
            r_o_dist    <= npe_pkg::DIST_W'(r_root);
            r_o_done    <= r_last;
        end
    end

    assign o_point_index   = r_o_idx;
    assign o_distance      = r_o_dist;
    assign o_set_done      = r_o_done;
    assign o_closest_index = r_o_closest;

endmodule

@@ rtl/nearest_point_euclid3d.sv @@
// Top level of the 3D nearest-point search block.
// Instantiates npe_ctrl and npe_dpath; depends on npe_pkg.
//
// Each candidate point yields one result: its index in the set, the floor square root
// of its squared distance to the configured reference point, the set-end flag and the
// index of the nearest point so far (later point wins a tie). One transaction is in work
// at a time: the block accepts a point and captures it, squares and accumulates the
// three differences on the shared squarer, updates the running best, runs the bit-serial
// square root (one result bit per cycle) and loads the output register, and only then
// accepts the next point. A finished result waits in the output register while the
// next point is accepted; the block stalls only if a second result finishes before the
// first is taken. The running best and the item count clear after the point flagged
// last.
module nearest_point_euclid3d #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [npe_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [npe_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [npe_pkg::PT_W-1:0]  i_pt_x,
    input  logic signed [npe_pkg::PT_W-1:0]  i_pt_y,
    input  logic signed [npe_pkg::PT_W-1:0]  i_pt_z,
    input  logic                             i_last_point,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [npe_pkg::IDX_OUT_W-1:0]    o_point_index,
    output logic [npe_pkg::DIST_W-1:0]       o_distance,
    output logic                             o_set_done,
    output logic [npe_pkg::IDX_OUT_W-1:0]    o_closest_index
);

    npe_pkg::t_dp_cmd cmd;

    npe_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    npe_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_pt_x          (i_pt_x),
        .i_pt_y          (i_pt_y),
        .i_pt_z          (i_pt_z),
        .i_last_point    (i_last_point),
        .i_cmd           (cmd),
        .o_point_index   (o_point_index),
        .o_distance      (o_distance),
        .o_set_done      (o_set_done),
        .o_closest_index (o_closest_index)
    );

    // At most one datapath operation per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.sq_step, cmd.best, cmd.root_step, cmd.out_load}))
        else $error("more than one datapath command active");

    // An accepted point keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready high right after an accepted point");

    // Loading the output register raises valid on the next cycle.
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("output load did not raise valid");

endmodule
